[sv/dpp_pkg.sv]
package dpp_pkg;

   localparam int ROW_W      = 10;
   localparam int COL_W      = 10;
   localparam int RAW_W      = 16;
   localparam int SIZE_W     = 11;
   localparam int FOCAL_W    = 18;
   localparam int DEPTH_W    = 16;
   localparam int PXY_W      = 16;
   localparam int PZ_W       = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // radicand gets 20 zero bits appended, numerator scaled by 2*1024
   localparam int RAD_PAD   = 20;
   localparam int NUM_SHIFT = 11;
   localparam int QUO_W     = 16;

   localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 11'd320;
   localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 11'd240;
   localparam logic [FOCAL_W-1:0] RST_FOCAL_X      = 18'd50339;
   localparam logic [FOCAL_W-1:0] RST_FOCAL_Y      = 18'd50457;
   localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH    = 16'd10;
   localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH    = 16'd30000;

   localparam logic [PXY_W-1:0] SAT_POS   = 16'h7FFF;
   localparam logic [PXY_W-1:0] SAT_NEG   = 16'h8000;
   localparam logic [PZ_W-1:0]  SAT_Z     = 15'h7FFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_FOCAL_X      = 3'd2,
      CSR_FOCAL_Y      = 3'd3,
      CSR_MIN_DEPTH    = 3'd4,
      CSR_MAX_DEPTH    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [PXY_W-1:0] point_x;
      logic signed [PXY_W-1:0] point_y;
      logic [PZ_W-1:0]         point_z;
   } point_type;

endpackage

[sv/dpp_req_if.sv]
interface dpp_req_if;
   logic                        valid;
   logic                        ready;
   logic [dpp_pkg::ROW_W-1:0]   pixel_row;
   logic [dpp_pkg::COL_W-1:0]   pixel_col;
   logic [dpp_pkg::RAW_W-1:0]   raw_depth;

   modport source (output valid, output pixel_row, output pixel_col, output raw_depth,
                   input ready);
   modport sink   (input valid, input pixel_row, input pixel_col, input raw_depth,
                   output ready);
endinterface

[sv/dpp_rsp_if.sv]
interface dpp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [dpp_pkg::PXY_W-1:0]   point_x;
   logic signed [dpp_pkg::PXY_W-1:0]   point_y;
   logic [dpp_pkg::PZ_W-1:0]           point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

[sv/dpp_div.sv]
// pipelined restoring divider, one quotient bit per stage
module dpp_div #(
   parameter int DEN_W = 18,
   parameter int LOW_W = 19,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [DEN_W-1:0] rem_i,
   input  logic [LOW_W-1:0] low_i,
   input  logic [DEN_W-1:0] den_i,
   input  logic [TAG_W-1:0] tag_i,
   output logic [LOW_W-1:0] quo_o,
   output logic [TAG_W-1:0] tag_o
);

   logic [DEN_W-1:0] rem_ff [LOW_W];
   logic [LOW_W-1:0] low_ff [LOW_W];
   logic [DEN_W-1:0] den_ff [LOW_W];
   logic [TAG_W-1:0] tag_ff [LOW_W];

   genvar k;
   generate
      for (k = 0; k < LOW_W; k++) begin : g_stage
         logic [DEN_W-1:0] rem_src;
         logic [DEN_W-1:0] den_src;
         logic [LOW_W-1:0] low_src;
         logic [TAG_W-1:0] tag_src;
         logic [DEN_W:0]   trial;
         logic [DEN_W:0]   diff;
         logic [DEN_W-1:0] rem_in;
         logic [LOW_W-1:0] low_in;

         if (k == 0) begin : g_first
            assign rem_src = rem_i;
            assign low_src = low_i;
            assign den_src = den_i;
            assign tag_src = tag_i;
         end else begin : g_next
            assign rem_src = rem_ff[k-1];
            assign low_src = low_ff[k-1];
            assign den_src = den_ff[k-1];
            assign tag_src = tag_ff[k-1];
         end

         always_comb begin
            trial = {rem_src, low_src[LOW_W-1]};
            diff  = trial - {1'b0, den_src};
            if (trial >= {1'b0, den_src}) begin
               rem_in = diff[DEN_W-1:0];
               low_in = {low_src[LOW_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DEN_W-1:0];
               low_in = {low_src[LOW_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               low_ff[k] <= low_in;
               den_ff[k] <= den_src;
               tag_ff[k] <= tag_src;
            end
         end
      end
   endgenerate

   assign quo_o = low_ff[LOW_W-1];
   assign tag_o = tag_ff[LOW_W-1];

endmodule

[sv/dpp_sqrt.sv]
// pipelined integer square root, one root bit per stage
module dpp_sqrt #(
   parameter int RAD_W = 58,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [RAD_W-1:0]     rad_i,
   input  logic [TAG_W-1:0]     tag_i,
   output logic [RAD_W/2-1:0]   root_o,
   output logic [TAG_W-1:0]     tag_o
);

   localparam int RT_W = RAD_W / 2;

   logic [RT_W:0]      rem_ff  [RT_W];
   logic [RT_W-1:0]    root_ff [RT_W];
   logic [RAD_W-1:0]   rad_ff  [RT_W];
   logic [TAG_W-1:0]   tag_ff  [RT_W];

   genvar k;
   generate
      for (k = 0; k < RT_W; k++) begin : g_stage
         logic [RT_W:0]    rem_src;
         logic [RT_W-1:0]  root_src;
         logic [RAD_W-1:0] rad_src;
         logic [TAG_W-1:0] tag_src;
         logic [RT_W+2:0]  part;
         logic [RT_W+2:0]  trial;
         logic [RT_W+2:0]  diff;
         logic [RT_W:0]    rem_in;
         logic [RT_W-1:0]  root_in;
         logic [RAD_W-1:0] rad_in;

         if (k == 0) begin : g_first
            assign rem_src  = '0;
            assign root_src = '0;
            assign rad_src  = rad_i;
            assign tag_src  = tag_i;
         end else begin : g_next
            assign rem_src  = rem_ff[k-1];
            assign root_src = root_ff[k-1];
            assign rad_src  = rad_ff[k-1];
            assign tag_src  = tag_ff[k-1];
         end

         always_comb begin
            part   = {rem_src, rad_src[RAD_W-1:RAD_W-2]};
            trial  = {1'b0, root_src, 2'b01};
            diff   = part - trial;
            rad_in = {rad_src[RAD_W-3:0], 2'b00};
            if (part >= trial) begin
               rem_in  = diff[RT_W:0];
               root_in = {root_src[RT_W-2:0], 1'b1};
            end else begin
               rem_in  = part[RT_W:0];
               root_in = {root_src[RT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               rad_ff[k]  <= rad_in;
               tag_ff[k]  <= tag_src;
            end
         end
      end
   endgenerate

   assign root_o = root_ff[RT_W-1];
   assign tag_o  = tag_ff[RT_W-1];

endmodule

[sv/depth_pixel_to_point.sv]
// throughput: one pixel per cycle while the queue has room; set by the bit-per-stage dividers
// and square root, which with six plain register stages make a 2*COORD_BITS+50 stage
// pipeline on one enable; a two-entry result queue takes the output, the pipeline holds
// only when it is full; reset (synchronous, active high) clears all valid bits and the queue,
// loads the registers with their defaults; pixels outside the depth window give no result
module depth_pixel_to_point #(
   parameter int COORD_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   dpp_req_if.sink                         req,
   dpp_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [dpp_pkg::CSR_IDX_W-1:0]   csr_idx,
   input  logic [dpp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // widths that follow from the coordinate precision
   localparam int A_W     = COORD_BITS + 9;           // normalized coordinate
   localparam int Q_W     = 2 * COORD_BITS + 18;      // a^2 + b^2 + 1
   localparam int RAD_W   = Q_W + dpp_pkg::RAD_PAD;
   localparam int RT_W    = RAD_W / 2;
   localparam int DEN_W   = RT_W + 2;                 // 3 * root
   localparam int PROD_W  = dpp_pkg::RAW_W + A_W;
   localparam int NH_W    = PROD_W + dpp_pkg::NUM_SHIFT + 1;
   localparam int N_STG   = 1 + A_W + 3 + RT_W + 2 + dpp_pkg::QUO_W;
   localparam int XT_W    = dpp_pkg::RAW_W + 3;
   localparam int ST_W    = dpp_pkg::RAW_W + 2 + 2 * A_W;
   localparam logic [A_W-1:0] A_LIMIT = A_W'(1) << (COORD_BITS + 8);
   localparam logic [Q_W-1:0] ONE_SQ  = Q_W'(1) << (2 * COORD_BITS);

   // ---------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------
   logic [dpp_pkg::SIZE_W-1:0]  width_ff;
   logic [dpp_pkg::SIZE_W-1:0]  height_ff;
   logic [dpp_pkg::FOCAL_W-1:0] focal_x_ff;
   logic [dpp_pkg::FOCAL_W-1:0] focal_y_ff;
   logic [dpp_pkg::DEPTH_W-1:0] min_depth_ff;
   logic [dpp_pkg::DEPTH_W-1:0] max_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= dpp_pkg::RST_IMAGE_WIDTH;
         height_ff    <= dpp_pkg::RST_IMAGE_HEIGHT;
         focal_x_ff   <= dpp_pkg::RST_FOCAL_X;
         focal_y_ff   <= dpp_pkg::RST_FOCAL_Y;
         min_depth_ff <= dpp_pkg::RST_MIN_DEPTH;
         max_depth_ff <= dpp_pkg::RST_MAX_DEPTH;
      end else if (csr_we) begin
         unique case (csr_idx)
            dpp_pkg::CSR_IMAGE_WIDTH:  width_ff     <= csr_wdata[dpp_pkg::SIZE_W-1:0];
            dpp_pkg::CSR_IMAGE_HEIGHT: height_ff    <= csr_wdata[dpp_pkg::SIZE_W-1:0];
            dpp_pkg::CSR_FOCAL_X:      focal_x_ff   <= csr_wdata[dpp_pkg::FOCAL_W-1:0];
            dpp_pkg::CSR_FOCAL_Y:      focal_y_ff   <= csr_wdata[dpp_pkg::FOCAL_W-1:0];
            dpp_pkg::CSR_MIN_DEPTH:    min_depth_ff <= csr_wdata[dpp_pkg::DEPTH_W-1:0];
            dpp_pkg::CSR_MAX_DEPTH:    max_depth_ff <= csr_wdata[dpp_pkg::DEPTH_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // a zero focal length behaves as one
   logic [dpp_pkg::FOCAL_W-1:0] fx_eff;
   logic [dpp_pkg::FOCAL_W-1:0] fy_eff;
   assign fx_eff = (focal_x_ff == '0) ? dpp_pkg::FOCAL_W'(1) : focal_x_ff;
   assign fy_eff = (focal_y_ff == '0) ? dpp_pkg::FOCAL_W'(1) : focal_y_ff;

   // ---------------------------------------------------------------------------
   // flow control: the whole pipeline moves on pipe_en, which depends only on
   // the queue fill, so rsp.ready never reaches req.ready combinationally
   // ---------------------------------------------------------------------------
   logic [1:0]        cnt_ff;
   logic              pipe_en;
   logic              accept;
   logic [N_STG-1:0]  vld_ff;
   logic              in_win;

   assign pipe_en   = (cnt_ff != 2'd2);
   assign req.ready = pipe_en;
   assign accept    = req.valid && pipe_en;
   assign in_win    = (req.raw_depth >= min_depth_ff) && (req.raw_depth <= max_depth_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[N_STG-2:0], accept && in_win};
      end
   end

   // ---------------------------------------------------------------------------
   // stage 1: centre offsets in half-pixel units, sign and overflow check
   // ---------------------------------------------------------------------------
   logic [dpp_pkg::SIZE_W-1:0] two_c;
   logic [dpp_pkg::SIZE_W-1:0] two_r;
   logic                       negx_in;
   logic                       negy_in;
   logic [dpp_pkg::SIZE_W-1:0] magx_in;
   logic [dpp_pkg::SIZE_W-1:0] magy_in;
   logic                       ovfx_in;
   logic                       ovfy_in;

   always_comb begin
      two_c   = {req.pixel_col, 1'b0};
      two_r   = {req.pixel_row, 1'b0};
      negx_in = two_c < width_ff;
      negy_in = two_r < height_ff;
      magx_in = negx_in ? (width_ff - two_c) : (two_c - width_ff);
      magy_in = negy_in ? (height_ff - two_r) : (two_r - height_ff);
      // quotient would reach 2^(COORD_BITS+9): saturate without dividing
      ovfx_in = {9'd0, magx_in} >= {fx_eff, 2'b00};
      ovfy_in = {9'd0, magy_in} >= {fy_eff, 2'b00};
   end

   logic [dpp_pkg::SIZE_W-1:0] p1_magx_ff;
   logic [dpp_pkg::SIZE_W-1:0] p1_magy_ff;
   logic                       p1_negx_ff;
   logic                       p1_negy_ff;
   logic                       p1_ovfx_ff;
   logic                       p1_ovfy_ff;
   logic [dpp_pkg::RAW_W-1:0]  p1_raw_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p1_magx_ff <= magx_in;
         p1_magy_ff <= magy_in;
         p1_negx_ff <= negx_in;
         p1_negy_ff <= negy_in;
         p1_ovfx_ff <= ovfx_in;
         p1_ovfy_ff <= ovfy_in;
         p1_raw_ff  <= req.raw_depth;
      end
   end

   // ---------------------------------------------------------------------------
   // offset * 2^(COORD_BITS+7) / focal, one quotient bit per stage
   // the top of the dividend, offset >> 2, is already below the focal length
   // ---------------------------------------------------------------------------
   logic [A_W-1:0]  qa;
   logic [A_W-1:0]  qb;
   logic [XT_W-1:0] xt_out;
   logic            yt_out;

   dpp_div #(.DEN_W(dpp_pkg::FOCAL_W), .LOW_W(A_W), .TAG_W(XT_W)) u_div_a (
      .clock (clock),
      .en    (pipe_en),
      .rem_i (dpp_pkg::FOCAL_W'(p1_magx_ff[dpp_pkg::SIZE_W-1:2])),
      .low_i ({p1_magx_ff[1:0], {(A_W-2){1'b0}}}),
      .den_i (fx_eff),
      .tag_i ({p1_raw_ff, p1_negx_ff, p1_negy_ff, p1_ovfx_ff}),
      .quo_o (qa),
      .tag_o (xt_out)
   );

   dpp_div #(.DEN_W(dpp_pkg::FOCAL_W), .LOW_W(A_W), .TAG_W(1)) u_div_b (
      .clock (clock),
      .en    (pipe_en),
      .rem_i (dpp_pkg::FOCAL_W'(p1_magy_ff[dpp_pkg::SIZE_W-1:2])),
      .low_i ({p1_magy_ff[1:0], {(A_W-2){1'b0}}}),
      .den_i (fy_eff),
      .tag_i (p1_ovfy_ff),
      .quo_o (qb),
      .tag_o (yt_out)
   );

   // ---------------------------------------------------------------------------
   // saturate a, b to 256, square, sum with one
   // ---------------------------------------------------------------------------
   logic [A_W-1:0]            s2_a_ff;
   logic [A_W-1:0]            s2_b_ff;
   logic [dpp_pkg::RAW_W-1:0] s2_raw_ff;
   logic                      s2_negx_ff;
   logic                      s2_negy_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_a_ff    <= (xt_out[0] || qa > A_LIMIT) ? A_LIMIT : qa;
         s2_b_ff    <= (yt_out || qb > A_LIMIT) ? A_LIMIT : qb;
         s2_raw_ff  <= xt_out[XT_W-1:3];
         s2_negx_ff <= xt_out[2];
         s2_negy_ff <= xt_out[1];
      end
   end

   logic [Q_W-1:0]            s3_aa_ff;
   logic [Q_W-1:0]            s3_bb_ff;
   logic [A_W-1:0]            s3_a_ff;
   logic [A_W-1:0]            s3_b_ff;
   logic [dpp_pkg::RAW_W-1:0] s3_raw_ff;
   logic                      s3_negx_ff;
   logic                      s3_negy_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_aa_ff   <= Q_W'(s2_a_ff) * Q_W'(s2_a_ff);
         s3_bb_ff   <= Q_W'(s2_b_ff) * Q_W'(s2_b_ff);
         s3_a_ff    <= s2_a_ff;
         s3_b_ff    <= s2_b_ff;
         s3_raw_ff  <= s2_raw_ff;
         s3_negx_ff <= s2_negx_ff;
         s3_negy_ff <= s2_negy_ff;
      end
   end

   logic [Q_W-1:0]            s4_q_ff;
   logic [A_W-1:0]            s4_a_ff;
   logic [A_W-1:0]            s4_b_ff;
   logic [dpp_pkg::RAW_W-1:0] s4_raw_ff;
   logic                      s4_negx_ff;
   logic                      s4_negy_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_q_ff    <= s3_aa_ff + s3_bb_ff + ONE_SQ;
         s4_a_ff    <= s3_a_ff;
         s4_b_ff    <= s3_b_ff;
         s4_raw_ff  <= s3_raw_ff;
         s4_negx_ff <= s3_negx_ff;
         s4_negy_ff <= s3_negy_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // root = floor(sqrt(q * 2^20)), one bit per stage
   // ---------------------------------------------------------------------------
   logic [RT_W-1:0] root;
   logic [ST_W-1:0] st_out;

   dpp_sqrt #(.RAD_W(RAD_W), .TAG_W(ST_W)) u_sqrt (
      .clock  (clock),
      .en     (pipe_en),
      .rad_i  ({s4_q_ff, {dpp_pkg::RAD_PAD{1'b0}}}),
      .tag_i  ({s4_raw_ff, s4_negx_ff, s4_negy_ff, s4_a_ff, s4_b_ff}),
      .root_o (root),
      .tag_o  (st_out)
   );

   logic [dpp_pkg::RAW_W-1:0] sq_raw;
   logic [A_W-1:0]            sq_a;
   logic [A_W-1:0]            sq_b;

   assign sq_raw = st_out[ST_W-1 -: dpp_pkg::RAW_W];
   assign sq_a   = st_out[2*A_W-1:A_W];
   assign sq_b   = st_out[A_W-1:0];

   // ---------------------------------------------------------------------------
   // divisor 3*root, products raw*a, raw*b, raw*one
   // ---------------------------------------------------------------------------
   logic [DEN_W-1:0]  s5_den_ff;
   logic [PROD_W-1:0] s5_px_ff;
   logic [PROD_W-1:0] s5_py_ff;
   logic [PROD_W-1:0] s5_pz_ff;
   logic              s5_negx_ff;
   logic              s5_negy_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_den_ff  <= DEN_W'({root, 1'b0}) + DEN_W'(root);
         s5_px_ff   <= PROD_W'(sq_raw) * PROD_W'(sq_a);
         s5_py_ff   <= PROD_W'(sq_raw) * PROD_W'(sq_b);
         s5_pz_ff   <= PROD_W'(sq_raw) << COORD_BITS;
         s5_negx_ff <= st_out[2*A_W+1];
         s5_negy_ff <= st_out[2*A_W];
      end
   end

   // ---------------------------------------------------------------------------
   // rounded numerator and quotient overflow (result would reach 2^16)
   // ---------------------------------------------------------------------------
   logic [NH_W-1:0] nhx_in;
   logic [NH_W-1:0] nhy_in;
   logic [NH_W-1:0] nhz_in;
   logic [NH_W-1:0] den_hi;

   always_comb begin
      den_hi = {s5_den_ff, {dpp_pkg::QUO_W{1'b0}}};
      nhx_in = NH_W'({s5_px_ff, {dpp_pkg::NUM_SHIFT{1'b0}}})
             + NH_W'(s5_den_ff[DEN_W-1:1]);
      nhy_in = NH_W'({s5_py_ff, {dpp_pkg::NUM_SHIFT{1'b0}}})
             + NH_W'(s5_den_ff[DEN_W-1:1]);
      nhz_in = NH_W'({s5_pz_ff, {dpp_pkg::NUM_SHIFT{1'b0}}})
             + NH_W'(s5_den_ff[DEN_W-1:1]);
   end

   logic [NH_W-1:0]  s6_nhx_ff;
   logic [NH_W-1:0]  s6_nhy_ff;
   logic [NH_W-1:0]  s6_nhz_ff;
   logic [DEN_W-1:0] s6_den_ff;
   logic             s6_ovfx_ff;
   logic             s6_ovfy_ff;
   logic             s6_ovfz_ff;
   logic             s6_negx_ff;
   logic             s6_negy_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s6_nhx_ff  <= nhx_in;
         s6_nhy_ff  <= nhy_in;
         s6_nhz_ff  <= nhz_in;
         s6_den_ff  <= s5_den_ff;
         s6_ovfx_ff <= nhx_in >= den_hi;
         s6_ovfy_ff <= nhy_in >= den_hi;
         s6_ovfz_ff <= nhz_in >= den_hi;
         s6_negx_ff <= s5_negx_ff;
         s6_negy_ff <= s5_negy_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // three dividers sharing the divisor, 16 quotient bits each
   // ---------------------------------------------------------------------------
   logic [dpp_pkg::QUO_W-1:0] qx;
   logic [dpp_pkg::QUO_W-1:0] qy;
   logic [dpp_pkg::QUO_W-1:0] qz;
   logic [2:0]                ox_tag;
   logic                      oy_tag;
   logic                      oz_tag;

   dpp_div #(.DEN_W(DEN_W), .LOW_W(dpp_pkg::QUO_W), .TAG_W(3)) u_div_x (
      .clock (clock),
      .en    (pipe_en),
      .rem_i (s6_nhx_ff[NH_W-1:dpp_pkg::QUO_W]),
      .low_i (s6_nhx_ff[dpp_pkg::QUO_W-1:0]),
      .den_i (s6_den_ff),
      .tag_i ({s6_negx_ff, s6_negy_ff, s6_ovfx_ff}),
      .quo_o (qx),
      .tag_o (ox_tag)
   );

   dpp_div #(.DEN_W(DEN_W), .LOW_W(dpp_pkg::QUO_W), .TAG_W(1)) u_div_y (
      .clock (clock),
      .en    (pipe_en),
      .rem_i (s6_nhy_ff[NH_W-1:dpp_pkg::QUO_W]),
      .low_i (s6_nhy_ff[dpp_pkg::QUO_W-1:0]),
      .den_i (s6_den_ff),
      .tag_i (s6_ovfy_ff),
      .quo_o (qy),
      .tag_o (oy_tag)
   );

   dpp_div #(.DEN_W(DEN_W), .LOW_W(dpp_pkg::QUO_W), .TAG_W(1)) u_div_z (
      .clock (clock),
      .en    (pipe_en),
      .rem_i (s6_nhz_ff[NH_W-1:dpp_pkg::QUO_W]),
      .low_i (s6_nhz_ff[dpp_pkg::QUO_W-1:0]),
      .den_i (s6_den_ff),
      .tag_i (s6_ovfz_ff),
      .quo_o (qz),
      .tag_o (oz_tag)
   );

   // ---------------------------------------------------------------------------
   // sign and saturation
   // ---------------------------------------------------------------------------
   dpp_pkg::point_type pt_in;

   always_comb begin
      if (ox_tag[2]) begin
         pt_in.point_x = (ox_tag[0] || qx > dpp_pkg::SAT_NEG) ? dpp_pkg::SAT_NEG
                                                             : dpp_pkg::PXY_W'(16'd0 - qx);
      end else begin
         pt_in.point_x = (ox_tag[0] || qx[15]) ? dpp_pkg::SAT_POS : qx;
      end
      if (ox_tag[1]) begin
         pt_in.point_y = (oy_tag || qy > dpp_pkg::SAT_NEG) ? dpp_pkg::SAT_NEG
                                                          : dpp_pkg::PXY_W'(16'd0 - qy);
      end else begin
         pt_in.point_y = (oy_tag || qy[15]) ? dpp_pkg::SAT_POS : qy;
      end
      pt_in.point_z = (oz_tag || qz[15]) ? dpp_pkg::SAT_Z : qz[dpp_pkg::PZ_W-1:0];
   end

   // ---------------------------------------------------------------------------
   // two-entry result queue: only when both entries are full does a stalled result stop the pipeline
   // ---------------------------------------------------------------------------
   dpp_pkg::point_type q_mem [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic               push;
   logic               pop;

   assign push = pipe_en && vld_ff[N_STG-1];
   assign pop  = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= pt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign rsp.valid   = (cnt_ff != 2'd0);
   assign rsp.point_x = q_mem[rd_ptr_ff].point_x;
   assign rsp.point_y = q_mem[rd_ptr_ff].point_y;
   assign rsp.point_z = q_mem[rd_ptr_ff].point_z;

   // ---------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------
   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue overfilled");

   a_window_drop : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.raw_depth < min_depth_ff ||
       req.raw_depth > max_depth_ff)) |=> !vld_ff[0])
      else $error("out-of-window pixel entered the pipeline");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline moved while held");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("queue count lost a transfer");

endmodule
